@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the checker file of the ordered queue.
// The enclosing scope must provide clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at each rising clock edge, skipped while reset is low
`define OQPR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every rising clock edge, reset included
`define OQPR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/oqpr_pkg.sv @@
// Package for the ordered queue: field widths, request and status codes,
// sequencer state type and the result record. No dependencies.
package oqpr_pkg;

    // Field widths
    localparam int REQ_W      = 3;
    localparam int ID_W       = 16;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 5;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 24;

    // Parameter defaults
    localparam int DEPTH_DEF   = 16;
    localparam int ID_BITS_DEF = 16;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_REMOVE     = 3'd2;
    localparam logic [REQ_W-1:0] REQ_LIST       = 3'd3;
    localparam logic [REQ_W-1:0] REQ_CLEAR      = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_EMPTY     = 2'd3;

    // Sequencer states
    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_SRCH_RD  = 7'b0000010,
        S_SRCH_CMP = 7'b0000100,
        S_SH_RD    = 7'b0001000,
        S_SH_WR    = 7'b0010000,
        S_LIST_RD  = 7'b0100000,
        S_LIST_OUT = 7'b1000000
    } state_t;

    // One result record
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     entry_id;
        logic [COUNT_W-1:0]  entry_count;
        logic                last;
    } result_t;

endpackage

@@ hw/rtl/oqpr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for the queue entry store.
module oqpr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port, holds until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/oqpr_addr.sv @@
// Shared address unit: maps a queue position to a physical slot of the
// circular entry store, (base + offset) mod DEPTH. No dependencies.
module oqpr_addr #(
    parameter int DEPTH = 16
) (
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] base,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] offset,
    output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW:0] DEPTH_C = (AW + 1)'(DEPTH);

    logic [AW:0] sum;
    logic [AW:0] wrapped;

    // Add, then fold back once past the end of the store
    always_comb
    begin
        sum     = {1'b0, base} + {1'b0, offset};
        wrapped = sum - DEPTH_C;
        addr    = (sum >= DEPTH_C) ? wrapped[AW-1:0] : sum[AW-1:0];
    end

endmodule

@@ hw/rtl/ordered_queue_push_remove.sv @@
// Top level of the ordered queue with push at either end and remove by id.
// Uses oqpr_pkg, oqpr_addr (slot address unit) and oqpr_ram (entry store).
//
// Channel  Dir  Payload                                   Handshake
// s_*      in   tuser: req_type; tdata: proc_id           s_tvalid/s_tready
// m_*      out  tuser: status; tdata: entry_id, count;    m_tvalid/m_tready
//               tlast: last
//
// Push, clear and unknown requests: one result, shown in the cycle after accept.
// Remove: states S_SRCH_RD, S_SRCH_CMP per entry compared, S_SH_RD, S_SH_WR per
// entry moved up; list: S_LIST_RD, S_LIST_OUT per entry, waiting in S_LIST_OUT
// while the output register is blocked. Each step is one pass through the shared
// slot address unit and the single store port.
// A request is taken only in idle with the output register free or draining.
// Reset (async, low) empties the queue; stored ids are not cleared.
module ordered_queue_push_remove #(
    parameter int DEPTH   = oqpr_pkg::DEPTH_DEF,
    parameter int ID_BITS = oqpr_pkg::ID_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [oqpr_pkg::IN_DATA_W-1:0]   s_tdata,   // [15:0] proc_id
    input  logic [oqpr_pkg::REQ_W-1:0]       s_tuser,   // [2:0] req_type
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [oqpr_pkg::OUT_DATA_W-1:0]  m_tdata,   // [15:0] entry_id,
                                                        // [20:16] entry_count
    output logic [oqpr_pkg::STATUS_W-1:0]    m_tuser,   // [1:0] status
    output logic                             m_tlast    // last
);

    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int SW    = (ID_BITS < oqpr_pkg::ID_W) ? ID_BITS : oqpr_pkg::ID_W;
    localparam int IDW   = oqpr_pkg::ID_W;
    localparam int CNTW  = oqpr_pkg::COUNT_W;
    localparam int PADW  = oqpr_pkg::OUT_DATA_W - IDW - CNTW;
    localparam logic [AW-1:0] LAST_OFF = AW'(DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);
    localparam logic [CW-1:0] ONE_C    = CW'(1);

    oqpr_pkg::state_t  state_reg, state_next;
    logic [AW-1:0]     head_reg, head_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     off_reg, off_next;
    logic [SW-1:0]     id_reg, id_next;
    logic              out_valid_reg, out_valid_next;
    oqpr_pkg::result_t out_reg, out_next;

    logic [CW-1:0]     off_plus;
    logic [CW-1:0]     count_m1;
    logic [AW-1:0]     slot_off;
    logic [AW-1:0]     slot_addr;
    logic              ram_we;
    logic              ram_re;
    logic [SW-1:0]     ram_wdata;
    logic [SW-1:0]     ram_rdata;
    logic              s_accept;
    logic              out_free;

    assign off_plus = off_reg + ONE_C;
    assign count_m1 = count_reg - ONE_C;
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == oqpr_pkg::S_IDLE) && out_free;
    assign s_accept = s_tvalid && s_tready;

    // Pick the queue position that the address unit maps this cycle
    always_comb
    begin
        unique case (state_reg)
            oqpr_pkg::S_IDLE:
            begin
                if (s_tuser == oqpr_pkg::REQ_PUSH_FRONT)
                begin
                    slot_off = LAST_OFF;
                end
                else
                begin
                    slot_off = count_reg[AW-1:0];
                end
            end
            oqpr_pkg::S_SH_RD: slot_off = off_plus[AW-1:0];
            default:           slot_off = off_reg[AW-1:0];
        endcase
    end

    oqpr_addr #(
        .DEPTH (DEPTH)
    ) u_addr (
        .base   (head_reg),
        .offset (slot_off),
        .addr   (slot_addr)
    );

    oqpr_ram #(
        .WIDTH (SW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_addr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (slot_addr),
        .rdata (ram_rdata)
    );

    // Sequence each request through the store and load results
    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        off_next       = off_reg;
        id_next        = id_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_next       = out_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_wdata      = s_tdata[SW-1:0];

        unique case (state_reg)
            oqpr_pkg::S_IDLE:
            begin
                if (s_accept)
                begin
                    id_next        = s_tdata[SW-1:0];
                    out_valid_next = 1'b1;
                    out_next       = '{status: oqpr_pkg::STAT_OK, entry_id: '0,
                                       entry_count: CNTW'(count_reg), last: 1'b1};
                    case (s_tuser) inside
                        oqpr_pkg::REQ_PUSH_FRONT, oqpr_pkg::REQ_PUSH_BACK:
                        begin
                            if (count_reg == DEPTH_C)
                            begin
                                out_next.status = oqpr_pkg::STAT_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                count_next = count_reg + ONE_C;
                                out_next.entry_count = CNTW'(count_reg + ONE_C);
                                if (s_tuser == oqpr_pkg::REQ_PUSH_FRONT)
                                begin
                                    head_next = slot_addr;
                                end
                            end
                        end
                        oqpr_pkg::REQ_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                out_next.status = oqpr_pkg::STAT_NOT_FOUND;
                            end
                            else
                            begin
                                out_valid_next = 1'b0;
                                off_next       = '0;
                                state_next     = oqpr_pkg::S_SRCH_RD;
                            end
                        end
                        oqpr_pkg::REQ_LIST:
                        begin
                            if (count_reg == '0)
                            begin
                                out_next.status = oqpr_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                out_valid_next = 1'b0;
                                off_next       = '0;
                                state_next     = oqpr_pkg::S_LIST_RD;
                            end
                        end
                        oqpr_pkg::REQ_CLEAR:
                        begin
                            count_next           = '0;
                            out_next.entry_count = '0;
                        end
                        default:
                        begin
                            // unknown request: answer ok, queue untouched
                        end
                    endcase
                end
            end

            oqpr_pkg::S_SRCH_RD:
            begin
                ram_re     = 1'b1;
                state_next = oqpr_pkg::S_SRCH_CMP;
            end

            oqpr_pkg::S_SRCH_CMP:
            begin
                if (ram_rdata == id_reg)
                begin
                    if (off_reg < count_m1)
                    begin
                        state_next = oqpr_pkg::S_SH_RD;
                    end
                    else
                    begin
                        count_next     = count_m1;
                        out_valid_next = 1'b1;
                        out_next       = '{status: oqpr_pkg::STAT_OK, entry_id: '0,
                                           entry_count: CNTW'(count_m1), last: 1'b1};
                        state_next     = oqpr_pkg::S_IDLE;
                    end
                end
                else if (off_plus == count_reg)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '{status: oqpr_pkg::STAT_NOT_FOUND, entry_id: '0,
                                       entry_count: CNTW'(count_reg), last: 1'b1};
                    state_next     = oqpr_pkg::S_IDLE;
                end
                else
                begin
                    off_next   = off_plus;
                    state_next = oqpr_pkg::S_SRCH_RD;
                end
            end

            oqpr_pkg::S_SH_RD:
            begin
                ram_re     = 1'b1;
                state_next = oqpr_pkg::S_SH_WR;
            end

            oqpr_pkg::S_SH_WR:
            begin
                // move the next entry up one place
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
                off_next  = off_plus;
                if (off_plus < count_m1)
                begin
                    state_next = oqpr_pkg::S_SH_RD;
                end
                else
                begin
                    count_next     = count_m1;
                    out_valid_next = 1'b1;
                    out_next       = '{status: oqpr_pkg::STAT_OK, entry_id: '0,
                                       entry_count: CNTW'(count_m1), last: 1'b1};
                    state_next     = oqpr_pkg::S_IDLE;
                end
            end

            oqpr_pkg::S_LIST_RD:
            begin
                ram_re     = 1'b1;
                state_next = oqpr_pkg::S_LIST_OUT;
            end

            oqpr_pkg::S_LIST_OUT:
            begin
                // hold the read entry until the output register frees up
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '{status: oqpr_pkg::STAT_OK,
                                       entry_id: IDW'(ram_rdata),
                                       entry_count: CNTW'(count_reg),
                                       last: (off_plus == count_reg)};
                    if (off_plus == count_reg)
                    begin
                        state_next = oqpr_pkg::S_IDLE;
                    end
                    else
                    begin
                        off_next   = off_plus;
                        state_next = oqpr_pkg::S_LIST_RD;
                    end
                end
            end

            default:
            begin
                state_next = oqpr_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= oqpr_pkg::S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            off_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            off_reg       <= off_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        id_reg  <= id_next;
        out_reg <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {PADW'(0), out_reg.entry_count, out_reg.entry_id};
    assign m_tuser  = out_reg.status;
    assign m_tlast  = out_reg.last;

endmodule

@@ hw/rtl/oqpr_checker.sv @@
// Port-level checker for the ordered queue, bound to the top level.
// Uses oqpr_pkg and the macros of assert_macros.svh.
`include "assert_macros.svh"

module oqpr_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [oqpr_pkg::IN_DATA_W-1:0]   s_tdata,
    input logic [oqpr_pkg::REQ_W-1:0]       s_tuser,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [oqpr_pkg::OUT_DATA_W-1:0]  m_tdata,
    input logic [oqpr_pkg::STATUS_W-1:0]    m_tuser,
    input logic                             m_tlast
);

    // A stalled result holds its payload
    `OQPR_ASSERT(a_out_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast)), "stalled result changed")

    // A request is taken only when the output register can take a result
    `OQPR_ASSERT_ALWAYS(a_ready_room, s_tready |-> (!m_tvalid || m_tready), "request taken with output blocked")

    // Any result other than ok is a single final result with no id
    `OQPR_ASSERT(a_error_single, (m_tvalid && m_tuser != oqpr_pkg::STAT_OK) |-> (m_tlast && m_tdata[15:0] == 16'd0), "error result not final or carries an id")

    // A list of an empty queue reports no entries
    `OQPR_ASSERT(a_empty_count, (m_tvalid && m_tuser == oqpr_pkg::STAT_EMPTY) |-> (m_tdata[20:16] == 5'd0), "empty list with nonzero count")

    // No new request while a list is still streaming
    `OQPR_ASSERT(a_list_busy, (m_tvalid && !m_tlast) |-> !s_tready, "request taken in the middle of a list")

endmodule

bind ordered_queue_push_remove oqpr_checker u_oqpr_checker (.*);

@@ tb/sv/ordered_queue_push_remove_tb.sv @@
// Self-checking bench for ordered_queue_push_remove: directed requests, then
// random request traffic under several idle/stall mixes, checked in order.
// Depends on oqpr_pkg and the ordered_queue_push_remove RTL.
module ordered_queue_push_remove_tb;

    localparam int DEPTH       = oqpr_pkg::DEPTH_DEF;
    localparam int REQ_W       = oqpr_pkg::REQ_W;
    localparam int ID_W        = oqpr_pkg::ID_W;
    localparam int STATUS_W    = oqpr_pkg::STATUS_W;
    localparam int COUNT_W     = oqpr_pkg::COUNT_W;
    localparam int IN_DATA_W   = oqpr_pkg::IN_DATA_W;
    localparam int OUT_DATA_W  = oqpr_pkg::OUT_DATA_W;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 400;
    localparam int RAND_PHASES = 4;
    localparam int PHASE_ITEMS = 90;
    localparam int N_ROWS      = 18;

    // Request codes the block treats as no-ops
    localparam logic [REQ_W-1:0] REQ_RSVD_5 = 3'd5;
    localparam logic [REQ_W-1:0] REQ_RSVD_6 = 3'd6;
    localparam logic [REQ_W-1:0] REQ_RSVD_7 = 3'd7;

    typedef struct packed {
        logic [REQ_W-1:0]    kind;
        logic [ID_W-1:0]     id;
        logic [4:0]          reps;    // sent this many times, id bumped each time
        logic                typed;   // reply given in the row, single result
        logic [STATUS_W-1:0] st;
        logic [COUNT_W-1:0]  cnt;
    } stim_row_t;

    // Directed script: replies typed in where obvious, otherwise predicted
    stim_row_t script [N_ROWS] = '{
        '{oqpr_pkg::REQ_LIST,       16'h0000, 5'd1, 1'b1, oqpr_pkg::STAT_EMPTY,     5'd0},
        '{oqpr_pkg::REQ_REMOVE,     16'h0000, 5'd1, 1'b1, oqpr_pkg::STAT_NOT_FOUND, 5'd0},
        '{REQ_RSVD_5,               16'hFFFF, 5'd1, 1'b1, oqpr_pkg::STAT_OK,        5'd0},
        '{REQ_RSVD_6,               16'h5A5A, 5'd1, 1'b1, oqpr_pkg::STAT_OK,        5'd0},
        '{REQ_RSVD_7,               16'h0000, 5'd1, 1'b1, oqpr_pkg::STAT_OK,        5'd0},
        '{oqpr_pkg::REQ_PUSH_BACK,  16'h1234, 5'd1, 1'b0, oqpr_pkg::STAT_OK,        5'd0},
        '{oqpr_pkg::REQ_PUSH_FRONT, 16'hFFFF, 5'd1, 1'b0, oqpr_pkg::STAT_OK,        5'd0},
        '{oqpr_pkg::REQ_PUSH_BACK,  16'h0000, 5'd1, 1'b0, oqpr_pkg::STAT_OK,        5'd0},
        '{oqpr_pkg::REQ_PUSH_FRONT, 16'h1234, 5'd1, 1'b0, oqpr_pkg::STAT_OK,        5'd0},
        '{oqpr_pkg::REQ_PUSH_BACK,  16'h8001, 5'd6, 1'b0, oqpr_pkg::STAT_OK,        5'd0},
        '{oqpr_pkg::REQ_PUSH_FRONT, 16'h7FF0, 5'd6, 1'b0, oqpr_pkg::STAT_OK,        5'd0},
        '{oqpr_pkg::REQ_PUSH_BACK,  16'hAAAA, 5'd1, 1'b1, oqpr_pkg::STAT_FULL,      5'd16},
        '{oqpr_pkg::REQ_PUSH_FRONT, 16'h5555, 5'd1, 1'b1, oqpr_pkg::STAT_FULL,      5'd16},
        '{oqpr_pkg::REQ_REMOVE,     16'h1234, 5'd1, 1'b0, oqpr_pkg::STAT_OK,        5'd0},
        '{oqpr_pkg::REQ_REMOVE,     16'hBEEF, 5'd1, 1'b0, oqpr_pkg::STAT_OK,        5'd0},
        '{oqpr_pkg::REQ_LIST,       16'h0000, 5'd1, 1'b0, oqpr_pkg::STAT_OK,        5'd0},
        '{oqpr_pkg::REQ_CLEAR,      16'h0000, 5'd1, 1'b1, oqpr_pkg::STAT_OK,        5'd0},
        '{oqpr_pkg::REQ_LIST,       16'h0000, 5'd1, 1'b1, oqpr_pkg::STAT_EMPTY,     5'd0}
    };

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [REQ_W-1:0]      s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]   m_tuser;
    logic                  m_tlast;

    // Reply given with the request on the bus, if any
    logic                  drv_typed = 1'b0;
    logic [STATUS_W-1:0]   drv_st = '0;
    logic [COUNT_W-1:0]    drv_cnt = '0;

    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  hold_arm = 1'b0;
    int  hold_left = 0;
    int  mismatch_count = 0;
    int  cycle_count = 0;

    logic [ID_W-1:0]   held_ids [$];         // queue contents, front first
    oqpr_pkg::result_t pending_replies [$];  // replies owed by the block, oldest first

    ordered_queue_push_remove DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [15:0] proc_id
        .s_tuser  (s_tuser),    // [2:0] req_type
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // [15:0] entry_id, [20:16] entry_count
        .m_tuser  (m_tuser),    // [1:0] status
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Apply one accepted request to the queue copy and owe its replies
    function automatic void apply_request(input logic [REQ_W-1:0] kind,
                                          input logic [ID_W-1:0] id);
        int                pos;
        oqpr_pkg::result_t r;
        pos = -1;
        r.status = oqpr_pkg::STAT_OK;
        r.entry_id = '0;
        r.last = 1'b1;
        case (kind)
            oqpr_pkg::REQ_PUSH_FRONT:
                if (held_ids.size() >= DEPTH)
                    r.status = oqpr_pkg::STAT_FULL;
                else
                    held_ids.push_front(id);
            oqpr_pkg::REQ_PUSH_BACK:
                if (held_ids.size() >= DEPTH)
                    r.status = oqpr_pkg::STAT_FULL;
                else
                    held_ids.push_back(id);
            oqpr_pkg::REQ_REMOVE:
            begin
                // only the match nearest the front goes
                for (int i = 0; i < held_ids.size() && pos < 0; i++)
                    if (held_ids[i] == id)
                        pos = i;
                if (pos < 0)
                    r.status = oqpr_pkg::STAT_NOT_FOUND;
                else
                    held_ids.delete(pos);
            end
            oqpr_pkg::REQ_LIST:
            begin
                if (held_ids.size() == 0)
                    r.status = oqpr_pkg::STAT_EMPTY;
                else
                begin
                    for (int i = 0; i < held_ids.size(); i++)
                    begin
                        r.entry_id = held_ids[i];
                        r.entry_count = COUNT_W'(held_ids.size());
                        r.last = (i == held_ids.size() - 1);
                        pending_replies.push_back(r);
                    end
                    return;
                end
            end
            oqpr_pkg::REQ_CLEAR:
                held_ids.delete();
            default:
                ;
        endcase
        r.entry_count = COUNT_W'(held_ids.size());
        pending_replies.push_back(r);
    endfunction

    // Pick a process id: often from a small set so duplicates show up
    function automatic logic [ID_W-1:0] pick_proc_id();
        if ($urandom_range(99) >= 35)
            return ID_W'($urandom);
        case ($urandom_range(5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h1234;
            3:       return 16'h00FF;
            4:       return 16'hA5A5;
            default: return 16'h8000;
        endcase
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Offer one request from a falling edge; return at the falling edge after accept
    task automatic send_req(input logic [REQ_W-1:0] kind, input logic [ID_W-1:0] id,
                            input logic typed, input logic [STATUS_W-1:0] st,
                            input logic [COUNT_W-1:0] cnt);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            s_tdata = IN_DATA_W'($urandom);
            s_tuser = REQ_W'($urandom);
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser = kind;
        s_tdata = id;
        drv_typed = typed;
        drv_st = st;
        drv_cnt = cnt;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Stop offering and wait for every owed reply
    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Drive ready: random stalls, or a long hold-off when armed
    always @(negedge clk)
    begin
        if (hold_arm && hold_left == 0)
        begin
            hold_left = HOLD_CYCLES;
            hold_arm = 1'b0;
        end
        if (hold_left != 0)
        begin
            m_tready = 1'b0;
            hold_left--;
        end
        else
            m_tready = ($urandom_range(99) >= recv_stall_pct);
    end

    // Check replies and record accepted requests at each rising edge
    always @(posedge clk)
    begin
        oqpr_pkg::result_t want;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[%0t] run exceeded %0d cycles", $time, CYCLE_LIMIT);
            $display("** ordered_queue_push_remove: FAILED **");
            $finish;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_replies.size() == 0)
                flag_mismatch("reply with nothing owed", m_tdata, 0);
            else
            begin
                want = pending_replies.pop_front();
                if (m_tuser !== want.status)
                    flag_mismatch("status", m_tuser, want.status);
                if (m_tdata[ID_W-1:0] !== want.entry_id)
                    flag_mismatch("entry_id", m_tdata[ID_W-1:0], want.entry_id);
                if (m_tdata[ID_W +: COUNT_W] !== want.entry_count)
                    flag_mismatch("entry_count", m_tdata[ID_W +: COUNT_W],
                                  want.entry_count);
                if (m_tdata[OUT_DATA_W-1:ID_W+COUNT_W] !== '0)
                    flag_mismatch("tdata pad", m_tdata[OUT_DATA_W-1:ID_W+COUNT_W], 0);
                if (m_tlast !== want.last)
                    flag_mismatch("last", m_tlast, want.last);
            end
        end
        if (rst_n && s_tvalid && s_tready)
        begin
            apply_request(s_tuser, s_tdata[ID_W-1:0]);
            // swap in the reply typed with the request
            if (drv_typed)
            begin
                void'(pending_replies.pop_back());
                want.status = drv_st;
                want.entry_id = '0;
                want.entry_count = drv_cnt;
                want.last = 1'b1;
                pending_replies.push_back(want);
            end
        end
    end

    initial
    begin
        int               send_pct [RAND_PHASES];
        int               stall_pct [RAND_PHASES];
        int               roll;
        bit               draining;
        logic [REQ_W-1:0] kind;
        logic [ID_W-1:0]  id;

        send_pct = '{0, 79, 0, 16};
        stall_pct = '{0, 0, 79, 16};
        draining = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Walk the directed script
        foreach (script[r])
            for (int k = 0; k < script[r].reps; k++)
                send_req(script[r].kind, script[r].id + ID_W'(k), script[r].typed,
                         script[r].st, script[r].cnt);
        wait_drained();

        // Random traffic, one idle/stall mix per phase
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            send_idle_pct = send_pct[p];
            recv_stall_pct = stall_pct[p];
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // hold the output off long enough to back up the input
                if (p == 0 && i == 40)
                    hold_arm = 1'b1;

                // steer between filling and draining the queue
                if (held_ids.size() == DEPTH && $urandom_range(3) == 0)
                    draining = 1'b1;
                else if (held_ids.size() == 0)
                    draining = 1'b0;
                else if ($urandom_range(39) == 0)
                    draining = !draining;

                roll = $urandom_range(99);
                id = pick_proc_id();
                if (roll < (draining ? 10 : 30))
                    kind = oqpr_pkg::REQ_PUSH_FRONT;
                else if (roll < (draining ? 20 : 60))
                    kind = oqpr_pkg::REQ_PUSH_BACK;
                else if (roll < (draining ? 65 : 75))
                begin
                    kind = oqpr_pkg::REQ_REMOVE;
                    // mostly remove an id that is present
                    if (held_ids.size() != 0 && $urandom_range(99) < 65)
                        id = held_ids[$urandom_range(held_ids.size() - 1)];
                end
                else if (roll < (draining ? 85 : 90))
                    kind = oqpr_pkg::REQ_LIST;
                else if (roll < (draining ? 90 : 93))
                    kind = oqpr_pkg::REQ_CLEAR;
                else
                begin
                    case ($urandom_range(2))
                        0:       kind = REQ_RSVD_5;
                        1:       kind = REQ_RSVD_6;
                        default: kind = REQ_RSVD_7;
                    endcase
                end
                send_req(kind, id, 1'b0, oqpr_pkg::STAT_OK, '0);
            end
            wait_drained();
        end

        // Let any stray reply show up before the verdict
        repeat (100) @(posedge clk);
        if (mismatch_count == 0)
            $display("** ordered_queue_push_remove: PASSED **");
        else
            $display("** ordered_queue_push_remove: FAILED **");
        $finish;
    end

endmodule

@@ ordered_queue_push_remove.f @@
+incdir+hw/rtl
hw/rtl/oqpr_pkg.sv
hw/rtl/oqpr_ram.sv
hw/rtl/oqpr_addr.sv
hw/rtl/ordered_queue_push_remove.sv
hw/rtl/oqpr_checker.sv
tb/sv/ordered_queue_push_remove_tb.sv
